>>> rtl/core/bfrp_pkg.sv
// shared types, codes and the crc-16 step for the bootloader frame parser
package bfrp_pkg;

   // frame bytes
   localparam logic [7:0] START_CODE = 8'h5A;
   localparam logic [7:0] T_ACK      = 8'hA1;
   localparam logic [7:0] T_NAK      = 8'hA2;
   localparam logic [7:0] T_CMD      = 8'hA4;
   localparam logic [7:0] T_DATA     = 8'hA5;
   localparam logic [7:0] T_PING     = 8'hA6;
   localparam logic [7:0] T_PINGRSP  = 8'hA7;

   localparam logic [15:0] PINGRSP_LEN     = 16'd8;
   localparam logic [15:0] PINGRSP_CRC_LO  = 16'd6;
   localparam logic [15:0] CRC_POLY        = 16'h1021;

   // parser states
   localparam logic [2:0] ST_HUNT  = 3'd0;
   localparam logic [2:0] ST_TYPE  = 3'd1;
   localparam logic [2:0] ST_LENL  = 3'd2;
   localparam logic [2:0] ST_LENH  = 3'd3;
   localparam logic [2:0] ST_CRCL  = 3'd4;
   localparam logic [2:0] ST_CRCH  = 3'd5;
   localparam logic [2:0] ST_DATA  = 3'd6;

   // event codes
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_OK      = 3'd1;
   localparam logic [2:0] EV_CRC_ERR = 3'd2;
   localparam logic [2:0] EV_TYPE    = 3'd3;
   localparam logic [2:0] EV_CMD_LEN = 3'd4;

   // register indexes
   localparam logic CSR_IDX_CMD_LIMIT  = 1'b0;
   localparam logic CSR_IDX_DATA_LIMIT = 1'b1;

   localparam logic [15:0] LEN_LIMIT_RESET = 16'd32;

   typedef struct packed {
      logic [15:0] cmd_len_limit;
      logic [15:0] data_len_limit;
   } bfrp_cfg_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  frame_type;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic [15:0] frame_length;
      logic [15:0] received_crc;
   } bfrp_res_type;

   // one byte through crc-16, msb first
   function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] x;
      x = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
      end
      return x;
   endfunction

endpackage

>>> rtl/core/bfrp_if.sv
// valid/ready channel interfaces for received bytes and parse results
interface bfrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bfrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [7:0]  frame_type;
   logic        payload_valid;
   logic [7:0]  payload_byte;
   logic [15:0] payload_index;
   logic [15:0] frame_length;
   logic [15:0] received_crc;

   modport source (output valid, output event_res, output frame_type, output payload_valid,
                   output payload_byte, output payload_index, output frame_length,
                   output received_crc, input ready);
   modport sink   (input valid, input event_res, input frame_type, input payload_valid,
                   input payload_byte, input payload_index, input frame_length,
                   input received_crc, output ready);
endinterface

>>> rtl/core/bootloader_frame_receive_parser_top.sv
// top level of the serial bootloader frame receive parser
//
// usage
// - req channel: one received uart byte per item (rx_byte), valid/ready
// - rsp channel: one result item per byte: event code, frame type, payload
//   byte with its index, announced length and the crc carried in the frame
// - csr port: apb-style, cmd_len_limit at 0x0, data_len_limit at 0x4,
//   write only while no byte is in flight
// - path: a byte accepted goes into the input register, then through the
//   parser step into the result register
// - throughput: one byte per cycle while rsp is taken; the crc-16 step
//   is a single-byte xor network inside the parser step, which sets the cycle time
// - stall: when rsp is not taken the result register holds, the input
//   register still takes one more byte, then req_chan.ready drops
// - reset: both registers empty, parser hunting for the start byte,
//   length limits back to 32
module bootloader_frame_receive_parser_top
   import bfrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bfrp_req_if.sink    req_chan,
   bfrp_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   bfrp_cfg_type cfg;
   bfrp_res_type step_res;

   // input register
   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff, in_byte_in;
   // result register
   logic         out_valid_ff, out_valid_in;
   bfrp_res_type out_res_ff, out_res_in;

   logic out_load_ok;
   logic step_fire;
   logic req_take;

   bfrp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bfrp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step_fire),
      .rx_byte   (in_byte_ff),
      .cfg       (cfg),
      .res       (step_res)
   );

   // result register is free when empty or being drained this cycle
   assign out_load_ok    = !out_valid_ff || rsp_chan.ready;
   // parser advances only when the byte's result has somewhere to go
   assign step_fire      = in_valid_ff && out_load_ok;
   assign req_chan.ready = !in_valid_ff || step_fire;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
      if (req_take) begin
         in_byte_in = req_chan.rx_byte;
      end
      if (out_load_ok) begin
         out_valid_in = in_valid_ff;
      end
      if (step_fire) begin
         out_res_in = step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.event_res     = out_res_ff.event_res;
   assign rsp_chan.frame_type    = out_res_ff.frame_type;
   assign rsp_chan.payload_valid = out_res_ff.payload_valid;
   assign rsp_chan.payload_byte  = out_res_ff.payload_byte;
   assign rsp_chan.payload_index = out_res_ff.payload_index;
   assign rsp_chan.frame_length  = out_res_ff.frame_length;
   assign rsp_chan.received_crc  = out_res_ff.received_crc;

endmodule

>>> rtl/core/bfrp_csr.sv
// apb register block holding the command and data length limits
module bfrp_csr
   import bfrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready,
   output bfrp_cfg_type cfg
);

   bfrp_cfg_type cfg_ff, cfg_in;
   logic         reg_idx;
   logic         wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            CSR_IDX_CMD_LIMIT:  cfg_in.cmd_len_limit  = csr_pwdata[15:0];
            CSR_IDX_DATA_LIMIT: cfg_in.data_len_limit = csr_pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_IDX_CMD_LIMIT:  csr_prdata = {16'h0000, cfg_ff.cmd_len_limit};
         CSR_IDX_DATA_LIMIT: csr_prdata = {16'h0000, cfg_ff.data_len_limit};
         default:            csr_prdata = 32'h0000_0000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cmd_len_limit  <= LEN_LIMIT_RESET;
         cfg_ff.data_len_limit <= LEN_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/bfrp_parser.sv
// frame state machine: one byte per step, running crc and result forming
module bfrp_parser
   import bfrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_fire,
   input  logic [7:0]   rx_byte,
   input  bfrp_cfg_type cfg,
   output bfrp_res_type res
);

   logic [2:0]  state_ff, state_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] run_ff, run_in;
   logic [15:0] run_upd;
   logic [2:0]  ev;
   logic        pv;
   logic [7:0]  pb;
   logic [15:0] pidx;

   function automatic logic [2:0] finish_event(input logic [7:0] ftype,
                                                input logic [15:0] run, input logic [15:0] crc);
      if (ftype == T_CMD || ftype == T_DATA || ftype == T_PINGRSP) begin
         return (run == crc) ? EV_OK : EV_CRC_ERR;
      end
      return EV_OK;
   endfunction

   assign run_upd = crc16_add(run_ff, rx_byte);

   always_comb begin
      state_in = state_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      crc_in   = crc_ff;
      rem_in   = rem_ff;
      run_in   = run_ff;
      ev       = EV_NONE;
      pv       = 1'b0;
      pb       = 8'h00;
      pidx     = 16'h0000;
      unique case (state_ff)
         ST_HUNT: begin
            type_in = 8'h00;
            len_in  = 16'h0000;
            crc_in  = 16'h0000;
            rem_in  = 16'h0000;
            if (rx_byte == START_CODE) begin
               run_in   = crc16_add(16'h0000, rx_byte);
               state_in = ST_TYPE;
            end
         end
         ST_TYPE: begin
            type_in = rx_byte;
            run_in  = run_upd;
            if (rx_byte == T_PING || rx_byte == T_ACK || rx_byte == T_NAK) begin
               ev       = finish_event(rx_byte, run_upd, crc_ff);
               state_in = ST_HUNT;
            end else if (rx_byte == T_PINGRSP) begin
               len_in   = PINGRSP_LEN;
               rem_in   = PINGRSP_LEN;
               state_in = ST_DATA;
            end else if (rx_byte == T_CMD || rx_byte == T_DATA) begin
               state_in = ST_LENL;
            end else begin
               ev       = EV_TYPE;
               state_in = ST_HUNT;
            end
         end
         ST_LENL: begin
            len_in   = {8'h00, rx_byte};
            run_in   = run_upd;
            state_in = ST_LENH;
         end
         ST_LENH: begin
            len_in   = len_ff | {rx_byte, 8'h00};
            run_in   = run_upd;
            state_in = ST_CRCL;
         end
         ST_CRCL: begin
            crc_in   = {8'h00, rx_byte};
            state_in = ST_CRCH;
         end
         ST_CRCH: begin
            crc_in = crc_ff | {rx_byte, 8'h00};
            if (len_ff == 16'h0000) begin
               ev       = finish_event(type_ff, run_ff, crc_ff | {rx_byte, 8'h00});
               state_in = ST_HUNT;
            end else if (type_ff == T_CMD) begin
               if (len_ff > cfg.cmd_len_limit) begin
                  ev       = EV_CMD_LEN;
                  state_in = ST_HUNT;
               end else begin
                  rem_in   = len_ff;
                  state_in = ST_DATA;
               end
            end else begin
               // over-length data frame is dropped quietly
               if (len_ff > cfg.data_len_limit) begin
                  state_in = ST_HUNT;
               end else begin
                  rem_in   = len_ff;
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            pidx = len_ff - rem_ff;
            pv   = 1'b1;
            pb   = rx_byte;
            if (rem_ff != 16'h0000) begin
               rem_in = rem_ff - 16'd1;
            end
            if (type_ff == T_PINGRSP) begin
               // ping response: last two payload bytes are the crc
               if (pidx < PINGRSP_CRC_LO) begin
                  run_in = run_upd;
               end else if (pidx == PINGRSP_CRC_LO) begin
                  crc_in = {8'h00, rx_byte};
               end else begin
                  crc_in = crc_ff | {rx_byte, 8'h00};
               end
            end else begin
               run_in = run_upd;
            end
            if (rem_in == 16'h0000) begin
               ev       = finish_event(type_ff, run_in, crc_in);
               state_in = ST_HUNT;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         type_ff  <= 8'h00;
         len_ff   <= 16'h0000;
         crc_ff   <= 16'h0000;
         rem_ff   <= 16'h0000;
         run_ff   <= 16'h0000;
      end else if (step_fire) begin
         state_ff <= state_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         crc_ff   <= crc_in;
         rem_ff   <= rem_in;
         run_ff   <= run_in;
      end
   end

   always_comb begin
      res.event_res     = ev;
      res.frame_type    = type_in;
      res.payload_valid = pv;
      res.payload_byte  = pb;
      res.payload_index = pidx;
      res.frame_length  = len_in;
      res.received_crc  = crc_in;
   end

   // payload bytes only come out of the payload state
   a_pv_in_data: assert property (@(posedge clock) disable iff (reset)
      step_fire && pv |-> state_ff == ST_DATA)
      else $error("payload byte outside payload state");

   // any frame event sends the parser back to hunting
   a_event_restarts: assert property (@(posedge clock) disable iff (reset)
      step_fire && ev != EV_NONE |=> state_ff == ST_HUNT)
      else $error("parser did not return to hunting after an event");

   // unknown type is only flagged on the type byte
   a_type_err_src: assert property (@(posedge clock) disable iff (reset)
      step_fire && ev == EV_TYPE |-> state_ff == ST_TYPE)
      else $error("unknown type event outside type state");

   // payload state always has bytes left to take
   a_data_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DATA |-> rem_ff != 16'h0000)
      else $error("payload state entered with nothing remaining");

endmodule
